/* rtl/core/wspt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weld status power trim package
// Field widths, fixed constants and the types shared between the modules.
// ----------------------------------------------------------------------------
package wspt_pkg;

  localparam int unsigned STATUS_W = 4;
  localparam int unsigned FRAME_W  = 31;
  localparam int unsigned DB_W     = 16;
  localparam int unsigned CMD_W    = 32;
  localparam int unsigned TRIM_W   = 14;
  localparam int unsigned HOLD_W   = 10;

  // sized for the largest window of sixteen entries
  localparam int unsigned SUM_W  = 7;
  localparam int unsigned VAL_W  = 5;
  localparam int unsigned MAG_W  = 6;
  localparam int unsigned DEN_W  = 8;
  localparam int unsigned QUO_W  = 13;
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned QCNT_W = $clog2(QUO_W);

  localparam int unsigned ARM_MARGIN = 10;
  localparam logic [STATUS_W-1:0] VALID_LIMIT = 4'd4;
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 10'd20;

  localparam logic OP_RESULT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/wspt_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weld status power trim channels
// Valid/ready channels for weld result transactions and trim commands.
// ----------------------------------------------------------------------------
interface wspt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [wspt_pkg::STATUS_W-1:0] weld_code;
  logic [wspt_pkg::FRAME_W-1:0]  frame_no;
  logic [wspt_pkg::DB_W-1:0]     db_block;

  modport source (output valid, op, weld_code, frame_no, db_block, input ready);
  modport sink   (input valid, op, weld_code, frame_no, db_block, output ready);
endinterface

interface wspt_out_if;
  logic                              valid;
  logic                              ready;
  logic [wspt_pkg::CMD_W-1:0]        cmd_seq;
  logic signed [wspt_pkg::TRIM_W-1:0] power_trim;
  logic [wspt_pkg::DB_W-1:0]         db_block_out;
  logic [wspt_pkg::FRAME_W-1:0]      trig_frame;

  modport source (output valid, cmd_seq, power_trim, db_block_out, trig_frame,
                  input ready);
  modport sink   (input valid, cmd_seq, power_trim, db_block_out, trig_frame,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/weld_status_power_trim.sv */
// Flow: an armed transaction rotates the status chain through the window,
//   is checked and, if a command is due, runs the divider (13 quotient bits,
//   then done) and loads the command.
// Throughput: one transaction in flight; the next is taken in idle: straight
//   away (not armed), after the check (armed, no command) or after the load
//   and any output stall (command). Reset clears control state, holdoff = 20.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weld status power trim
// Keeps a drop-oldest queue count and a status window, issues trim commands.
// ----------------------------------------------------------------------------
module weld_status_power_trim #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned WINDOW      = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wspt_pkg::HOLD_W-1:0]   cfg_wdata_i,
  wspt_in_if.sink                            in_i,
  wspt_out_if.source                         out_o
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SCN_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                          state_q, state_d;
  logic [wspt_pkg::HOLD_W-1:0]         holdoff_q, holdoff_d;
  logic [FILL_W-1:0]                   fill_q, fill_d, fill_inc;
  logic [SCN_W-1:0]                    scan_q, scan_d;
  logic signed [wspt_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [wspt_pkg::VAL_W-1:0]          valid_q, valid_d;
  logic [wspt_pkg::FRAME_W-1:0]        last_alarm_q, last_alarm_d;
  logic [wspt_pkg::CMD_W-1:0]          cmd_cnt_q, cmd_cnt_d;
  logic [wspt_pkg::FRAME_W-1:0]        frame_q, frame_d;
  logic [wspt_pkg::DB_W-1:0]           db_q, db_d;
  logic                                out_valid_q, out_valid_d;
  logic [wspt_pkg::CMD_W-1:0]          out_cmd_q, out_cmd_d;
  logic signed [wspt_pkg::TRIM_W-1:0]  out_trim_q, out_trim_d;
  logic [wspt_pkg::DB_W-1:0]           out_db_q, out_db_d;
  logic [wspt_pkg::FRAME_W-1:0]        out_frame_q, out_frame_d;

  logic                                accept;
  logic                                push;
  logic                                rotate;
  logic                                armed;
  logic [2:0]                          term;
  logic                                term_ok;
  logic [wspt_pkg::MAG_W-1:0]          mag;
  logic                                swing;
  logic [wspt_pkg::FRAME_W:0]          diff;
  logic                                past_holdoff;
  logic                                load_out;
  logic [wspt_pkg::TRIM_W-1:0]         quot_ext;
  wspt_pkg::status_t                   tail;
  wspt_pkg::div_req_t                  div_req;
  wspt_pkg::div_rsp_t                  div_rsp;

  wspt_pkg::status_t chain_d [WINDOW];
  wspt_pkg::status_t chain_q [WINDOW];

  assign accept = in_i.valid && in_i.ready;
  assign push   = accept && (in_i.op == wspt_pkg::OP_RESULT);
  assign rotate = (state_q == ST_SCAN);
  assign tail   = chain_q[WINDOW-1];

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign chain_d[k] = push ? in_i.weld_code : tail;
    end else begin : g_body
      assign chain_d[k] = chain_q[k-1];
    end
    wspt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (push || rotate),
      .d_i     (chain_d[k]),
      .q_o     (chain_q[k])
    );
  end

  wspt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    fill_inc = (fill_q == FILL_W'(QUEUE_DEPTH)) ? fill_q : (fill_q + 1'b1);
    armed    = (32'(fill_inc) > 32'(QUEUE_DEPTH - wspt_pkg::ARM_MARGIN)) &&
               (32'(fill_inc) > 32'(WINDOW));

    term    = {1'b0, tail[1:0]} - 3'd2;
    term_ok = (tail < wspt_pkg::VALID_LIMIT);

    mag          = sum_q[wspt_pkg::SUM_W-1] ? wspt_pkg::MAG_W'(-sum_q)
                                            : wspt_pkg::MAG_W'(sum_q);
    swing        = ({1'b0, mag, 1'b0} > 8'(valid_q));
    diff         = {1'b0, frame_q} - {1'b0, last_alarm_q};
    past_holdoff = !diff[wspt_pkg::FRAME_W] &&
                   (diff[wspt_pkg::FRAME_W-1:0] > wspt_pkg::FRAME_W'(holdoff_q));

    div_req.start = (state_q == ST_CHK) && (valid_q != '0) && swing && past_holdoff;
    div_req.mag   = mag;
    div_req.den   = {valid_q, 3'b000} + {2'b00, valid_q, 1'b0};

    quot_ext = {1'b0, div_rsp.quot};
    load_out = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  end

  always_comb begin
    state_d      = state_q;
    holdoff_d    = cfg_we_i ? cfg_wdata_i : holdoff_q;
    fill_d       = fill_q;
    scan_d       = scan_q;
    sum_d        = sum_q;
    valid_d      = valid_q;
    last_alarm_d = last_alarm_q;
    cmd_cnt_d    = cmd_cnt_q;
    frame_d      = frame_q;
    db_d         = db_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_cmd_d    = out_cmd_q;
    out_trim_d   = out_trim_q;
    out_db_d     = out_db_q;
    out_frame_d  = out_frame_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.op == wspt_pkg::OP_CLEAR) begin
            fill_d       = '0;
            cmd_cnt_d    = '0;
            last_alarm_d = '0;
          end else begin
            fill_d  = fill_inc;
            frame_d = in_i.frame_no;
            db_d    = in_i.db_block;
            scan_d  = '0;
            sum_d   = '0;
            valid_d = '0;
            if (armed) begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (term_ok) begin
          sum_d   = sum_q + wspt_pkg::SUM_W'($signed(term));
          valid_d = valid_q + 1'b1;
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == SCN_W'(WINDOW - 1)) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        state_d = div_req.start ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          out_cmd_d    = cmd_cnt_q;
          out_trim_d   = sum_q[wspt_pkg::SUM_W-1] ? $signed(quot_ext) : -$signed(quot_ext);
          out_db_d     = db_q;
          out_frame_d  = frame_q;
          last_alarm_d = frame_q;
          cmd_cnt_d    = cmd_cnt_q + 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      holdoff_q    <= wspt_pkg::HOLDOFF_RESET;
      fill_q       <= '0;
      scan_q       <= '0;
      last_alarm_q <= '0;
      cmd_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      holdoff_q    <= holdoff_d;
      fill_q       <= fill_d;
      scan_q       <= scan_d;
      last_alarm_q <= last_alarm_d;
      cmd_cnt_q    <= cmd_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    valid_q     <= valid_d;
    frame_q     <= frame_d;
    db_q        <= db_d;
    out_cmd_q   <= out_cmd_d;
    out_trim_q  <= out_trim_d;
    out_db_q    <= out_db_d;
    out_frame_q <= out_frame_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.cmd_seq      = out_cmd_q;
  assign out_o.power_trim   = out_trim_q;
  assign out_o.db_block_out = out_db_q;
  assign out_o.trig_frame   = out_frame_q;

endmodule
`default_nettype wire

/* rtl/core/wspt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weld status window cell
// One status stage of the window chain; takes its neighbor's value on shift.
// ----------------------------------------------------------------------------
module wspt_cell (
  input  wire logic              clk_i,
  input  wire logic              shift_i,
  input  wspt_pkg::status_t      d_i,
  output wspt_pkg::status_t      q_o
);

  wspt_pkg::status_t status_q, status_d;

  always_comb begin
    status_d = shift_i ? d_i : status_q;
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign q_o = status_q;

endmodule
`default_nettype wire

/* rtl/core/wspt_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weld status trim divider
// Restoring divide of |sum| * 2^15 by 10 * valid, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module wspt_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wspt_pkg::div_req_t  req_i,
  output wspt_pkg::div_rsp_t  rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [wspt_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic [wspt_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [wspt_pkg::QUO_W-1:0]      quo_q, quo_d;
  logic [wspt_pkg::DEN_W-1:0]      den_q, den_d;
  logic [wspt_pkg::REM_W-1:0]      trial;
  logic [wspt_pkg::REM_W-1:0]      den_ext;
  logic                            fits;

  always_comb begin
    trial   = {rem_q[wspt_pkg::REM_W-2:0], 1'b0};
    den_ext = {1'b0, den_q};
    fits    = (trial >= den_ext);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // upper dividend bits: |sum| * 2^15 shifted down by the quotient width
      rem_d  = {1'b0, req_i.mag, 2'b00};
      quo_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? (trial - den_ext) : trial;
      quo_d = {quo_q[wspt_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == wspt_pkg::QCNT_W'(wspt_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
`default_nettype wire

/* rtl/core/wspt_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weld status power trim checker
// Port-level properties of the trim block, bound to the top level.
// ----------------------------------------------------------------------------
module wspt_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [wspt_pkg::CMD_W-1:0]        cmd_seq_i,
  input wire logic signed [wspt_pkg::TRIM_W-1:0] power_trim_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cmd_seq_i)
                                    && $stable(power_trim_i))
    else $error("command changed while stalled");

  a_trim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (power_trim_i >= -14'sd3277) && (power_trim_i <= 14'sd6554))
    else $error("power trim out of range");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("command appeared right after a transaction");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("input not ready when a command was loaded");

endmodule

bind weld_status_power_trim wspt_chk u_wspt_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cmd_seq_i    (out_o.cmd_seq),
  .power_trim_i (out_o.power_trim)
);
`default_nettype wire
